// ===== rtl/bfpha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpha_pkg
// Shared constants for the best-fit page heap allocator.
// ----------------------------------------------------------------------------
package bfpha_pkg;

  localparam int DIVW = 21;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

endpackage

// ===== rtl/bfpha_div.sv =====
// ----------------------------------------------------------------------------
// bfpha_div
// Splits a byte count into pages and in-page offset; the divisor is a power of
// two, so the quotient is a shift and the remainder a mask, registered once.
// ----------------------------------------------------------------------------
module bfpha_div #(
  parameter int DIVISOR = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bfpha_pkg::DIVW-1:0]     dividend,
  output logic                           done,
  output logic [bfpha_pkg::DIVW-1:0]     quotient,
  output logic [$clog2(DIVISOR)-1:0]     remainder
);
  import bfpha_pkg::*;

  localparam int SH = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quotient  <= dividend >> SH;
        remainder <= dividend[SH-1:0];
      end
    end
  end

endmodule

// ===== rtl/best_fit_page_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_heap_allocator_unit
// Page heap allocator: best-fit allocate with split, free with coalescing.
// ----------------------------------------------------------------------------
//  channel | signals                                        | role
//  in      | in_valid, in_stall, req_type, request_bytes,   | request word
//          | release_address                                |
//  out     | out_valid, out_stall, status, address,         | result word
//          | heap_pages                                     |
//
// One request at a time. Allocate: page split and first read, a scan of one
// chunk per cycle (up to MAX_PAGES chunks), then decision, write-back and
// result. Free: page split and lookup of the freed chunk, a walk of one chunk
// per cycle over the chunks below the freed one, then lookups, write-back and
// result. The chunk memory has one read and one write port; the chunk
// walk is bound by its read latency.
// After reset a clearing pass over all MAX_PAGES chunk entries holds in_stall high.
// A waiting result does not block the next request word.
module best_fit_page_heap_allocator_unit #(
  parameter int MAX_PAGES    = 256,
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [19:0] request_bytes,
  input  logic [19:0] release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [19:0] address,
  output logic [8:0]  heap_pages
);
  import bfpha_pkg::*;

  localparam int LW  = $clog2(MAX_PAGES + 1);
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int MW  = LW + 1;
  localparam int AW  = LW + 18;
  localparam int RMW = $clog2(PAGE_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_SCAN_RQ, S_SCAN, S_A_DEC, S_F_RQ, S_F_CHK,
    S_W_RQ, S_WALK, S_F_DEC, S_N_RQ, S_NX, S_WR, S_RES
  } state_t;

  state_t st;

  logic [MW-1:0] mem [MAX_PAGES];
  logic [MW-1:0] mem_rd;
  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic [PW-1:0] mem_ra;

  logic          rd_used;
  logic [LW-1:0] rd_len;
  logic [LW:0]   nxt;

  logic [LW-1:0] ptr;
  logic [LW-1:0] top;
  logic [LW-1:0] need;
  logic [LW-1:0] best;
  logic [LW-1:0] best_len;
  logic          found;
  logic [LW-1:0] fp;
  logic [LW-1:0] flen;
  logic [LW-1:0] prv;
  logic [LW-1:0] prv_len;
  logic          prv_used;
  logic          prv_found;
  logic          prv_ok;
  logic [LW-1:0] nl;
  logic          rq_free;

  logic          w_en   [3];
  logic [PW-1:0] w_addr [3];
  logic [MW-1:0] w_data [3];
  logic [1:0]    wi;

  logic [1:0]    rs_status;
  logic          rs_grant;
  logic [LW-1:0] gpage;
  logic [AW-1:0] addr_full;

  logic            in_acc;
  logic            hdr_low;
  logic            div_start;
  logic [DIVW-1:0] div_dvd;
  logic            div_done;
  logic [DIVW-1:0] div_q;
  logic [RMW-1:0]  div_r;

  assign in_stall = (st != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign hdr_low  = {1'b0, release_address} < DIVW'(HEADER_BYTES);
  assign div_start = in_acc && (!req_type || !hdr_low);
  assign div_dvd  = req_type ? DIVW'(release_address) - DIVW'(HEADER_BYTES)
                             : DIVW'(request_bytes) + DIVW'(HEADER_BYTES);

  bfpha_div #(.DIVISOR(PAGE_BYTES)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign rd_used = mem_rd[LW];
  assign rd_len  = mem_rd[LW-1:0];
  assign nxt     = {1'b0, ptr} + {1'b0, rd_len};
  assign prv_ok  = prv_found && !prv_used;
  assign nl      = rd_used ? flen : flen + rd_len;

  assign mem_ra = (st == S_SCAN || st == S_WALK) ? nxt[PW-1:0] : ptr[PW-1:0];
  assign mem_we = (st == S_CLR) || (st == S_WR && w_en[wi]);
  assign mem_wa = (st == S_CLR) ? ptr[PW-1:0] : w_addr[wi];
  assign mem_wd = (st == S_CLR) ? '0 : w_data[wi];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  assign addr_full = AW'(gpage) * AW'(PAGE_BYTES) + AW'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      ptr       <= '0;
      top       <= '0;
      out_valid <= 1'b0;
      wi        <= '0;
      for (int i = 0; i < 3; i++) begin
        w_en[i] <= 1'b0;
      end
    end else begin
      if (out_valid && !out_stall && st != S_RES) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_CLR: begin
          ptr <= ptr + LW'(1);
          if (ptr == LW'(MAX_PAGES - 1)) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            rq_free   <= req_type;
            found     <= 1'b0;
            prv_found <= 1'b0;
            rs_grant  <= 1'b0;
            wi        <= '0;
            for (int i = 0; i < 3; i++) begin
              w_en[i] <= 1'b0;
            end
            if (req_type && hdr_low) begin
              rs_status <= ST_BADFREE;
              st        <= S_RES;
            end else begin
              st <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!rq_free) begin
              ptr  <= '0;
              need <= LW'(div_q[LW-1:0] + LW'(1));
              if (div_q >= DIVW'(MAX_PAGES)) begin
                rs_status <= ST_OOM;
                st        <= S_RES;
              end else if (top == '0) begin
                st <= S_A_DEC;
              end else begin
                st <= S_SCAN_RQ;
              end
            end else if (div_r != '0 || div_q >= DIVW'(top)) begin
              rs_status <= ST_BADFREE;
              st        <= S_RES;
            end else begin
              fp  <= div_q[LW-1:0];
              ptr <= div_q[LW-1:0];
              st  <= S_F_RQ;
            end
          end
        end
        S_SCAN_RQ: begin
          st <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_len != '0 && !rd_used && rd_len >= need &&
              (!found || rd_len < best_len)) begin
            found    <= 1'b1;
            best     <= ptr;
            best_len <= rd_len;
          end
          if (rd_len == '0 || nxt >= {1'b0, top}) begin
            st <= S_A_DEC;
          end else begin
            ptr <= nxt[LW-1:0];
          end
        end
        S_A_DEC: begin
          st <= S_WR;
          if (found) begin
            w_en[0]   <= best_len > need;
            w_addr[0] <= PW'(best + need);
            w_data[0] <= {1'b0, best_len - need};
            w_en[1]   <= 1'b1;
            w_addr[1] <= best[PW-1:0];
            w_data[1] <= {1'b1, need};
            rs_status <= ST_OK;
            rs_grant  <= 1'b1;
            gpage     <= best;
          end else if (MW'(top) + MW'(need) > MW'(MAX_PAGES)) begin
            rs_status <= ST_OOM;
          end else begin
            w_en[0]   <= 1'b1;
            w_addr[0] <= top[PW-1:0];
            w_data[0] <= {1'b1, need};
            rs_status <= ST_OK;
            rs_grant  <= 1'b1;
            gpage     <= top;
            top       <= top + need;
          end
        end
        S_F_RQ: begin
          st <= S_F_CHK;
        end
        S_F_CHK: begin
          flen <= rd_len;
          prv  <= fp;
          if (!rd_used) begin
            rs_status <= ST_BADFREE;
            st        <= S_RES;
          end else if (fp == '0) begin
            st <= S_F_DEC;
          end else begin
            ptr <= '0;
            st  <= S_W_RQ;
          end
        end
        S_W_RQ: begin
          st <= S_WALK;
        end
        S_WALK: begin
          if (rd_len == '0) begin
            st <= S_F_DEC;
          end else begin
            prv       <= ptr;
            prv_len   <= rd_len;
            prv_used  <= rd_used;
            prv_found <= 1'b1;
            if (nxt >= {1'b0, fp}) begin
              st <= S_F_DEC;
            end else begin
              ptr <= nxt[LW-1:0];
            end
          end
        end
        S_F_DEC: begin
          rs_status <= ST_OK;
          if (MW'(fp) + MW'(flen) >= MW'(top)) begin
            w_en[0]   <= 1'b1;
            w_addr[0] <= fp[PW-1:0];
            w_data[0] <= '0;
            if (prv_ok) begin
              w_en[1]   <= 1'b1;
              w_addr[1] <= prv[PW-1:0];
              w_data[1] <= '0;
              top       <= prv;
            end else begin
              top <= fp;
            end
            st <= S_WR;
          end else begin
            ptr <= fp + flen;
            st  <= S_N_RQ;
          end
        end
        S_N_RQ: begin
          st <= S_NX;
        end
        S_NX: begin
          w_en[0]   <= !rd_used;
          w_addr[0] <= ptr[PW-1:0];
          w_data[0] <= '0;
          w_en[1]   <= 1'b1;
          if (prv_ok) begin
            w_addr[1] <= prv[PW-1:0];
            w_data[1] <= {1'b0, prv_len + nl};
            w_en[2]   <= 1'b1;
            w_addr[2] <= fp[PW-1:0];
            w_data[2] <= '0;
          end else begin
            w_addr[1] <= fp[PW-1:0];
            w_data[1] <= {1'b0, nl};
          end
          st <= S_WR;
        end
        S_WR: begin
          if (wi == 2'd2) begin
            st <= S_RES;
          end else begin
            wi <= wi + 2'd1;
          end
        end
        S_RES: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= rs_status;
            address    <= rs_grant ? addr_full[19:0] : 20'd0;
            heap_pages <= 9'(top);
            st         <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bfpha_chk.sv =====
// ----------------------------------------------------------------------------
// bfpha_chk
// Port-level checks on the allocator result channel.
// ----------------------------------------------------------------------------
module bfpha_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [19:0] address,
  input logic [8:0]  heap_pages
);
  import bfpha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(address) && $stable(heap_pages))
    else $error("result word changed while stalled");

  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OOM || status == ST_BADFREE) |-> address == 20'd0)
    else $error("error result carries an address");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_OOM || status == ST_BADFREE)
    else $error("undefined status code");

endmodule

bind best_fit_page_heap_allocator_unit bfpha_chk u_bfpha_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .address    (address),
  .heap_pages (heap_pages)
);
